### design/wddc_pkg.sv
package wddc_pkg;

    localparam int SYMBOL_W = 8;
    localparam int COUNT_W  = 30;
    localparam int WEIGHT_W = 4;
    localparam int SUM_W    = 35;
    localparam int BUCKET_W = 8;
    localparam int BUCKET_LSB = SUM_W - BUCKET_W;

    typedef logic [SYMBOL_W-1:0] symbol_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [SUM_W-1:0]    sum_t;

    localparam count_t MODULUS = 30'd1000000007;

    localparam symbol_t CH_STAR = 8'h2A;
    localparam symbol_t CH_ZERO = 8'h30;
    localparam symbol_t CH_ONE  = 8'h31;
    localparam symbol_t CH_TWO  = 8'h32;
    localparam symbol_t CH_SIX  = 8'h36;
    localparam symbol_t CH_NINE = 8'h39;
    localparam symbol_t CH_NONE = 8'h00;

    localparam weight_t W_NONE      = 4'd0;
    localparam weight_t W_ONE       = 4'd1;
    localparam weight_t W_STAR_LOW  = 4'd2;
    localparam weight_t W_TWO_STAR  = 4'd6;
    localparam weight_t W_ALL       = 4'd9;
    localparam weight_t W_STAR_STAR = 4'd15;

    typedef struct packed {
        weight_t single;
        weight_t pair;
    } weights_t;

    // Largest multiple of MODULUS not above the low edge of each bucket of the sum.
    typedef sum_t qm_tab_t [2**BUCKET_W];

    function automatic qm_tab_t build_qm_tab();
        qm_tab_t t;
        for (int i = 0; i < 2**BUCKET_W; i++)
        begin
            t[i] = SUM_W'(((64'(i) << BUCKET_LSB) / 64'(MODULUS)) * 64'(MODULUS));
        end
        return t;
    endfunction

    localparam qm_tab_t QM_TAB = build_qm_tab();

endpackage

### design/wddc_if.sv
interface wddc_in_if import wddc_pkg::*; ();
    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    first;

    modport source (output valid, output symbol, output first, input ready);
    modport sink   (input valid, input symbol, input first, output ready);
endinterface

interface wddc_out_if import wddc_pkg::*; ();
    logic   valid;
    logic   ready;
    count_t count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);
endinterface

### design/wddc_weights.sv
module wddc_weights import wddc_pkg::*;
(
    input  symbol_t  prev_symbol,
    input  symbol_t  symbol,
    output weights_t weights
);

    logic prev_digit;
    logic cur_digit;
    logic cur_nonzero;

    assign prev_digit  = (prev_symbol >= CH_ZERO) && (prev_symbol <= CH_NINE);
    assign cur_digit   = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
    assign cur_nonzero = (symbol >= CH_ONE) && (symbol <= CH_NINE);

    always_comb
    begin
        if (symbol == CH_STAR)
        begin
            weights.single = W_ALL;
        end
        else if (cur_nonzero)
        begin
            weights.single = W_ONE;
        end
        else
        begin
            weights.single = W_NONE;
        end

        weights.pair = W_NONE;
        if (prev_digit && cur_digit)
        begin
            if ((prev_symbol == CH_ONE) || ((prev_symbol == CH_TWO) && (symbol <= CH_SIX)))
            begin
                weights.pair = W_ONE;
            end
        end
        else if (prev_digit && (symbol == CH_STAR))
        begin
            if (prev_symbol == CH_ONE)
            begin
                weights.pair = W_ALL;
            end
            else if (prev_symbol == CH_TWO)
            begin
                weights.pair = W_TWO_STAR;
            end
        end
        else if ((prev_symbol == CH_STAR) && cur_digit)
        begin
            weights.pair = (symbol <= CH_SIX) ? W_STAR_LOW : W_ONE;
        end
        else if ((prev_symbol == CH_STAR) && (symbol == CH_STAR))
        begin
            weights.pair = W_STAR_STAR;
        end
    end

endmodule

### design/wddc_update.sv
module wddc_update import wddc_pkg::*;
(
    input  count_t   count_last,
    input  count_t   count_before,
    input  weights_t weights,
    output count_t   count
);

    sum_t                sum;
    logic [BUCKET_W-1:0] bucket;
    sum_t                rem;

    assign sum    = SUM_W'(count_last) * SUM_W'(weights.single)
                  + SUM_W'(count_before) * SUM_W'(weights.pair);
    assign bucket = sum[SUM_W-1:BUCKET_LSB];
    // rem stays below MODULUS + 2**BUCKET_LSB, so one correction is enough
    assign rem    = sum - QM_TAB[bucket];

    always_comb
    begin
        if (rem >= SUM_W'(MODULUS))
        begin
            count = COUNT_W'(rem - SUM_W'(MODULUS));
        end
        else
        begin
            count = COUNT_W'(rem);
        end
    end

endmodule

### design/wildcard_digit_decode_counter_core.sv
// Wildcard digit decode counter.
// chars carries one character per transaction (symbol, first). counts
// returns one transaction per character: the number of ways, modulo
// 1000000007, to decode the string so far into letters 1..26, with '*'
// standing for any digit 1..9. first = 1 begins a new string.
// A character accepted into the input register moves to the output register,
// where its count transaction is offered, once that register is empty or its
// count is being taken. Throughput: one character per cycle while the receiver
// takes counts, set by the combinational count update (two small multiplies, a
// table guided reduction and one compare-subtract) that feeds the next character.
// Reset clears both stages and loads the state of an empty string, so the
// first character after reset behaves as if first were set.
// When the receiver stalls, the finished count holds in the output
// register, one more character is taken into the input register, and then
// chars.ready drops until the output transaction completes.
module wildcard_digit_decode_counter_core import wddc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    wddc_in_if.sink     chars,
    wddc_out_if.source  counts
);

    logic     s0_valid_reg;
    symbol_t  s0_symbol_reg;
    logic     s0_first_reg;
    logic     out_valid_reg;
    count_t   out_count_reg;
    symbol_t  prev_symbol_reg;
    count_t   count_last_reg;
    count_t   count_before_reg;

    logic     advance;
    logic     s0_valid_next;
    logic     out_valid_next;
    symbol_t  prev_eff;
    count_t   last_eff;
    count_t   before_eff;
    weights_t weights;
    count_t   count_next;

    assign advance       = s0_valid_reg && (!out_valid_reg || counts.ready);
    assign chars.ready   = !s0_valid_reg || advance;
    assign s0_valid_next = chars.ready ? chars.valid : s0_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !counts.ready);

    assign prev_eff   = s0_first_reg ? CH_NONE : prev_symbol_reg;
    assign last_eff   = s0_first_reg ? COUNT_W'(1) : count_last_reg;
    assign before_eff = s0_first_reg ? '0 : count_before_reg;

    wddc_weights u_weights
    (
        .prev_symbol (prev_eff),
        .symbol      (s0_symbol_reg),
        .weights     (weights)
    );

    wddc_update u_update
    (
        .count_last   (last_eff),
        .count_before (before_eff),
        .weights      (weights),
        .count        (count_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_symbol_reg  <= CH_NONE;
            count_last_reg   <= COUNT_W'(1);
            count_before_reg <= '0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                prev_symbol_reg  <= s0_symbol_reg;
                count_last_reg   <= count_next;
                count_before_reg <= last_eff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s0_symbol_reg <= chars.symbol;
            s0_first_reg  <= chars.first;
        end
        if (advance)
        begin
            out_count_reg <= count_next;
        end
    end

    assign counts.valid = out_valid_reg;
    assign counts.count = out_count_reg;

endmodule

### tb/sv/wildcard_digit_decode_counter_core_tb.sv
`timescale 1ns / 1ps

module wildcard_digit_decode_counter_core_tb import wddc_pkg::*;
;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int CODE_MIN     = 10;
    localparam int CODE_MAX     = 26;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wddc_in_if  chars_if ();
    wddc_out_if counts_if ();

    wildcard_digit_decode_counter_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .counts (counts_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    symbol_t prior_symbol;
    count_t  ways_last;
    count_t  ways_before;

    count_t  expected_counts [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    bit      no_gaps     = 1'b0;

    function automatic symbol_t digit(input int n);
        return symbol_t'(CH_ZERO + n);
    endfunction

    function automatic bit is_numeral(input symbol_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic weight_t single_weight_of(input symbol_t c);
        if (c == CH_STAR)
            return W_ALL;
        if ((c >= CH_ONE) && (c <= CH_NINE))
            return W_ONE;
        return W_NONE;
    endfunction

    function automatic weight_t pair_weight_of(input symbol_t a, input symbol_t b);
        int v;
        if (is_numeral(a) && is_numeral(b))
        begin
            v = (int'(a) - int'(CH_ZERO)) * 10 + (int'(b) - int'(CH_ZERO));
            return ((v >= CODE_MIN) && (v <= CODE_MAX)) ? W_ONE : W_NONE;
        end
        if (is_numeral(a) && (b == CH_STAR))
        begin
            if (a == CH_ONE)
                return W_ALL;
            if (a == CH_TWO)
                return W_TWO_STAR;
            return W_NONE;
        end
        if ((a == CH_STAR) && is_numeral(b))
            return (b <= CH_SIX) ? W_STAR_LOW : W_ONE;
        if ((a == CH_STAR) && (b == CH_STAR))
            return W_STAR_STAR;
        return W_NONE;
    endfunction

    function automatic count_t decode_count_step(input symbol_t sym, input logic first_flag);
        longint unsigned sum;
        if (first_flag)
        begin
            prior_symbol = CH_NONE;
            ways_last    = count_t'(1);
            ways_before  = count_t'(0);
        end
        sum = longint'(ways_last) * longint'(single_weight_of(sym))
            + longint'(ways_before) * longint'(pair_weight_of(prior_symbol, sym));
        sum = sum % longint'(MODULUS);
        ways_before  = ways_last;
        ways_last    = count_t'(sum);
        prior_symbol = sym;
        return count_t'(sum);
    endfunction

    task automatic send_char(input symbol_t sym, input logic first_flag);
        int gap;
        if (!no_gaps && (burst_left <= 0))
        begin
            gap = $urandom_range(1, 6);
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        chars_if.valid  <= 1'b1;
        chars_if.symbol <= sym;
        chars_if.first  <= first_flag;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        expected_counts.insert(expected_counts.size(), decode_count_step(sym, first_flag));
        burst_left--;
    endtask

    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    function automatic symbol_t pick_code_char();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 2)
            return CH_STAR;
        if (r <= 4)
            return CH_ONE;
        if (r == 5)
            return CH_TWO;
        return digit($urandom_range(0, 9));
    endfunction

    // no first flag right after reset
    task automatic test_after_reset();
        send_char(CH_ONE, 1'b0);
        send_char(CH_TWO, 1'b0);
        wait_drained();
    endtask

    task automatic test_wildcard_pairs();
        send_char(CH_STAR, 1'b1);
        send_char(CH_STAR, 1'b0);
        send_char(CH_ONE, 1'b1);
        send_char(CH_STAR, 1'b0);
        send_char(CH_TWO, 1'b1);
        send_char(CH_STAR, 1'b0);
        send_char(CH_STAR, 1'b1);
        send_char(CH_ZERO, 1'b0);
        send_char(CH_STAR, 1'b1);
        send_char(digit(7), 1'b0);
        send_char(CH_ZERO, 1'b1);
        send_char(CH_STAR, 1'b0);
        wait_drained();
    endtask

    task automatic test_digit_pairs();
        send_char(CH_ONE, 1'b1);
        send_char(CH_ZERO, 1'b0);
        send_char(CH_TWO, 1'b1);
        send_char(CH_SIX, 1'b0);
        send_char(CH_TWO, 1'b1);
        send_char(digit(7), 1'b0);
        send_char(digit(3), 1'b1);
        send_char(CH_ZERO, 1'b0);
        wait_drained();
    endtask

    task automatic test_other_chars();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(CH_NINE, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_strings();
        int sent;
        int len;
        sent = 0;
        no_gaps = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 200)
                no_gaps = 1'b0;
            if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 40)
                wait_drained();
            len = $urandom_range(1, 40);
            if ($urandom_range(0, 99) < 85)
            begin
                for (int i = 0; i < len; i++)
                    send_char(pick_code_char(),
                              (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
            end
            else
            begin
                for (int i = 0; i < len; i++)
                    send_char(symbol_t'($urandom_range(0, 255)),
                              logic'($urandom_range(0, 3) == 0));
            end
            sent += len;
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("wildcard_digit_decode_counter_core_tb: FAIL");
            $finish;
        end
    end

    // receiver stall pattern, chosen by bits 9:8 of cycle_count
    always @(posedge clk)
    begin
        case ((cycle_count >> 8) % 4)
            0:       counts_if.ready <= 1'b1;
            1:       counts_if.ready <= ($urandom_range(0, 9) < 7);
            2:       counts_if.ready <= ((cycle_count % 5) != 0);
            default: counts_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge clk)
    begin : check_count
        count_t want;
        if (rst_n && counts_if.valid && counts_if.ready)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("unexpected count transaction: actual %0d", counts_if.count);
                error_count++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (counts_if.count !== want)
                begin
                    $error("count mismatch: expected %0d, actual %0d", want, counts_if.count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        prior_symbol = CH_NONE;
        ways_last    = count_t'(1);
        ways_before  = count_t'(0);
        chars_if.valid  <= 1'b0;
        chars_if.symbol <= CH_NONE;
        chars_if.first  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_wildcard_pairs();
        test_digit_pairs();
        test_other_chars();
        test_random_strings();

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_counts.size() == 0)
            $display("wildcard_digit_decode_counter_core_tb: PASS");
        else
            $display("wildcard_digit_decode_counter_core_tb: FAIL");
        $finish;
    end

endmodule

### wildcard_digit_decode_counter_core.f
design/wddc_pkg.sv
design/wddc_if.sv
design/wddc_weights.sv
design/wddc_update.sv
design/wildcard_digit_decode_counter_core.sv
tb/sv/wildcard_digit_decode_counter_core_tb.sv
